FILE: rtl/lkbc_pkg.sv
// ----------------------------------------------------------------------------
// lkbc_pkg : shared types and constants of the keystream byte cipher
// register indexes, reset values, step limit and sequencer states
// ----------------------------------------------------------------------------
package lkbc_pkg;

    localparam int unsigned STEP_LIMIT = 1024;
    localparam int unsigned CNT_W      = $clog2(STEP_LIMIT);
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned DIN_W      = 8;
    localparam int unsigned KEY_W      = 32;
    localparam int unsigned POLY_A_W   = 31;
    localparam int unsigned OUT_W      = DIN_W + KEY_W;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEP_LIMIT - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_B    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_C    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_A    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_B    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_C    = 3'd6;

    // reset values
    localparam logic [POLY_A_W-1:0]   RST_POLY_A    = 31'h40c6e78f;
    localparam logic [KEY_W-1:0]      RST_POLY_B    = 32'h1;
    localparam logic [KEY_W-1:0]      RST_POLY_C    = 32'h1;
    localparam logic [KEY_W-1:0]      RST_SKIP_MASK = 32'h1;
    localparam logic [KEY_W-1:0]      RST_SEED_A    = 32'h1;
    localparam logic [KEY_W-1:0]      RST_SEED_B    = 32'h1;
    localparam logic [CFG_DATA_W-1:0] RST_SEED_C    = 64'h1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_FINISH
    } t_state;

endpackage

FILE: rtl/lfsr_keystream_byte_cipher.sv
// ----------------------------------------------------------------------------
// lfsr_keystream_byte_cipher : byte stream cipher from three coupled lfsrs
// each request byte is xored with the low byte of a keystream word
// ----------------------------------------------------------------------------
// Each byte runs through the sequencer with n (1 to 1024) register steps:
// idle takes the request, then step does one step of the shared register
// update per cycle until the low word of the 64-bit pair clears the skip
// mask or the step limit is reached, then finish hands the result to the
// output register once it is free. With the reset mask and random data n
// averages about two. A new byte is taken as soon as the sequencer is idle,
// even while the last result still waits in the output register.
// Configuration writes are always taken; seed writes load the state
// registers at once. The block both encrypts and decrypts.
module lfsr_keystream_byte_cipher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lkbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lkbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [lkbc_pkg::DIN_W-1:0]        s_axis_tdata,   // [7:0] data_in
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [lkbc_pkg::OUT_W-1:0]        m_axis_tdata    // [7:0] data_out, [39:8] key_word
);

    lkbc_pkg::t_state r_state, n_state;

    logic [lkbc_pkg::POLY_A_W-1:0] r_poly_a, n_poly_a;
    logic [lkbc_pkg::KEY_W-1:0]    r_poly_b, n_poly_b;
    logic [lkbc_pkg::KEY_W-1:0]    r_poly_c, n_poly_c;
    logic [lkbc_pkg::KEY_W-1:0]    r_mask,   n_mask;
    logic [lkbc_pkg::KEY_W-1:0]    r_a,      n_a;
    logic [lkbc_pkg::KEY_W-1:0]    r_b,      n_b;
    logic [lkbc_pkg::KEY_W-1:0]    r_c_high, n_c_high;
    logic [lkbc_pkg::KEY_W-1:0]    r_c_low,  n_c_low;
    logic [lkbc_pkg::CNT_W-1:0]    r_count,  n_count;
    logic [lkbc_pkg::DIN_W-1:0]    r_din,    n_din;
    logic                          r_out_valid, n_out_valid;
    logic [lkbc_pkg::DIN_W-1:0]    r_out_data,  n_out_data;
    logic [lkbc_pkg::KEY_W-1:0]    r_out_key,   n_out_key;

    // shared step unit
    logic [lkbc_pkg::KEY_W-1:0]    s_a, s_b, s_c_high, s_c_low;
    logic [lkbc_pkg::POLY_A_W-1:0] s_a_low;
    logic                          step_done;
    logic                          out_free;
    logic                          cfg_wr;
    logic                          in_acc;
    logic [lkbc_pkg::KEY_W-1:0]    key_now;

    always_comb begin
        // galois right shift of the low 31 bits, top bit from old reg_b
        s_a_low  = {1'b0, r_a[lkbc_pkg::POLY_A_W-1:1]}
                   ^ (r_a[0] ? r_poly_a : '0);
        s_a      = {r_b[lkbc_pkg::KEY_W-1], s_a_low};
        s_b      = {r_b[lkbc_pkg::KEY_W-2:0], 1'b0}
                   ^ (r_a[lkbc_pkg::KEY_W-1] ? r_poly_b : '0);
        s_c_high = {r_c_low[lkbc_pkg::KEY_W-1], r_c_high[lkbc_pkg::KEY_W-1:1]};
        s_c_low  = {r_c_low[lkbc_pkg::KEY_W-2:0], 1'b0}
                   ^ (r_c_high[0] ? r_poly_c : '0);
        step_done = ((s_c_low & r_mask) == '0) || (r_count == lkbc_pkg::CNT_LAST);
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid && o_cfg_ready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign key_now       = r_a ^ r_b;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_key, r_out_data};

    always_comb begin
        n_state     = r_state;
        n_poly_a    = r_poly_a;
        n_poly_b    = r_poly_b;
        n_poly_c    = r_poly_c;
        n_mask      = r_mask;
        n_a         = r_a;
        n_b         = r_b;
        n_c_high    = r_c_high;
        n_c_low     = r_c_low;
        n_count     = r_count;
        n_din       = r_din;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_key   = r_out_key;
        s_axis_tready = 1'b0;

        unique case (r_state)
            lkbc_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_din   = s_axis_tdata;
                    n_count = '0;
                    n_state = lkbc_pkg::ST_STEP;
                end
            end
            lkbc_pkg::ST_STEP: begin
                n_a      = s_a;
                n_b      = s_b;
                n_c_high = s_c_high;
                n_c_low  = s_c_low;
                n_count  = r_count + 1'b1;
                if (step_done) begin
                    n_state = lkbc_pkg::ST_FINISH;
                end
            end
            lkbc_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_din ^ key_now[lkbc_pkg::DIN_W-1:0];
                    n_out_key   = key_now;
                    n_state     = lkbc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lkbc_pkg::ST_IDLE;
            end
        endcase

        // the user must write only while the sequencer is idle; the block itself does not enforce it
        if (cfg_wr) begin
            unique case (i_cfg_index)
                lkbc_pkg::CFG_POLY_A:    n_poly_a = i_cfg_data[lkbc_pkg::POLY_A_W-1:0];
                lkbc_pkg::CFG_POLY_B:    n_poly_b = i_cfg_data[lkbc_pkg::KEY_W-1:0];
                lkbc_pkg::CFG_POLY_C:    n_poly_c = i_cfg_data[lkbc_pkg::KEY_W-1:0];
                lkbc_pkg::CFG_SKIP_MASK: n_mask   = i_cfg_data[lkbc_pkg::KEY_W-1:0];
                lkbc_pkg::CFG_SEED_A:    n_a      = i_cfg_data[lkbc_pkg::KEY_W-1:0];
                lkbc_pkg::CFG_SEED_B:    n_b      = i_cfg_data[lkbc_pkg::KEY_W-1:0];
                lkbc_pkg::CFG_SEED_C: begin
                    n_c_high = i_cfg_data[lkbc_pkg::CFG_DATA_W-1:lkbc_pkg::KEY_W];
                    n_c_low  = i_cfg_data[lkbc_pkg::KEY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkbc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly_a    <= lkbc_pkg::RST_POLY_A;
            r_poly_b    <= lkbc_pkg::RST_POLY_B;
            r_poly_c    <= lkbc_pkg::RST_POLY_C;
            r_mask      <= lkbc_pkg::RST_SKIP_MASK;
            r_a         <= lkbc_pkg::RST_SEED_A;
            r_b         <= lkbc_pkg::RST_SEED_B;
            r_c_high    <= lkbc_pkg::RST_SEED_C[lkbc_pkg::CFG_DATA_W-1:lkbc_pkg::KEY_W];
            r_c_low     <= lkbc_pkg::RST_SEED_C[lkbc_pkg::KEY_W-1:0];
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_poly_a    <= n_poly_a;
            r_poly_b    <= n_poly_b;
            r_poly_c    <= n_poly_c;
            r_mask      <= n_mask;
            r_a         <= n_a;
            r_b         <= n_b;
            r_c_high    <= n_c_high;
            r_c_low     <= n_c_low;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_din      <= n_din;
        r_out_data <= n_out_data;
        r_out_key  <= n_out_key;
    end

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == lkbc_pkg::ST_STEP) && (r_count == '0))
        else $error("accepted byte did not start stepping");

    a_count_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lkbc_pkg::ST_STEP) && !step_done
        |=> (r_state == lkbc_pkg::ST_STEP) && (r_count == $past(r_count) + 1'b1))
        else $error("step counter out of sequence");

    a_result_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lkbc_pkg::ST_FINISH) && out_free
        |=> m_axis_tvalid && (m_axis_tdata[lkbc_pkg::OUT_W-1:lkbc_pkg::DIN_W]
                              == $past(r_a ^ r_b)))
        else $error("result word does not match register state");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("pending result dropped");
`endif

endmodule
